// ----- rtl/frps_pkg.sv -----
package frps_pkg;

  // default sizes of the store
  localparam int DEF_MAX_PAGES = 32;
  localparam int DEF_MAX_SLOTS = 64;

  // widths that cover the whole parameter ranges
  localparam int PAGE_IDX_W = 6;
  localparam int REC_CNT_W  = 8;
  localparam int COST_W     = 17;

  localparam logic [15:0] PAGE_SIZE_RESET = 16'd4096;
  localparam logic [15:0] HEADER_BYTES    = 16'd16;
  localparam logic [16:0] RECORD_OVERHEAD = 17'd4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // result kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_PAGES  = 2'd2;
  localparam logic [1:0] KIND_PAGE   = 2'd3;

  // outcomes
  localparam logic [1:0] OUT_EXISTING = 2'd0;
  localparam logic [1:0] OUT_NEW      = 2'd1;
  localparam logic [1:0] OUT_UNFIT    = 2'd2;
  localparam logic [1:0] OUT_REFUSED  = 2'd3;
  localparam logic [1:0] OUT_FOUND    = 2'd0;
  localparam logic [1:0] OUT_ABSENT   = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_DONE,
    S_SRCH_PAGE,
    S_SRCH_CMP,
    S_SRCH_HIT,
    S_SRCH_MISS,
    S_REP_HEAD,
    S_REP_PAGE
  } state_t;

  // insert probe that walks down the page cells
  typedef struct packed {
    logic                  valid;
    logic                  placed;
    logic [COST_W-1:0]     cost;
    logic [PAGE_IDX_W-1:0] page;
    logic [REC_CNT_W-1:0]  slot;
  } probe_t;

  // page open command broadcast to all cells
  typedef struct packed {
    logic                  valid;
    logic [PAGE_IDX_W-1:0] page;
    logic [15:0]           free;
    logic                  fill;
  } open_t;

endpackage

// ----- rtl/frps_cell.sv -----
module frps_cell
  import frps_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  probe_t               probe_in,
  output probe_t               probe_out,
  input  open_t                open_cmd,
  output logic [REC_CNT_W-1:0] rec_count
);

  logic                 used;
  logic [15:0]          free;
  logic [REC_CNT_W-1:0] rec;
  logic                 fit;
  logic                 opening;

  // this page takes the probe's record
  assign fit = probe_in.valid && !probe_in.placed && used &&
               (rec < REC_CNT_W'(MAX_SLOTS)) && ({1'b0, free} >= probe_in.cost);
  assign opening = open_cmd.valid && (open_cmd.page == PAGE_IDX_W'(IDX));
  assign rec_count = rec;

  // page in use flag
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (opening) begin
      used <= 1'b1;
    end
  end

  // page space and record count
  always_ff @(posedge clk) begin
    if (opening) begin
      free <= open_cmd.free;
      rec  <= open_cmd.fill ? REC_CNT_W'(1) : '0;
    end else if (fit) begin
      free <= free - probe_in.cost[15:0];
      rec  <= rec + REC_CNT_W'(1);
    end
  end

  // hand the probe to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.cost <= probe_in.cost;
    if (fit) begin
      probe_out.placed <= 1'b1;
      probe_out.page   <= PAGE_IDX_W'(IDX);
      probe_out.slot   <= rec;
    end else begin
      probe_out.placed <= probe_in.placed;
      probe_out.page   <= probe_in.page;
      probe_out.slot   <= probe_in.slot;
    end
  end

endmodule

// ----- rtl/first_fit_record_page_store_core.sv -----
// channel  | direction | handshake         | payload
// in       | input     | in_valid/in_stall | command, key, record_size
// out      | output    | out_valid/out_stall | result_kind, outcome, page_index,
//          |           |                   | slot_index, count, last
// cfg      | input     | cfg_we            | cfg_data (page_size)
//
// insert: the probe walks the row of page cells, then S_INS_DONE writes the result
// search: walks the pages in use and compares each stored key (key memory read port)
// report: 1 + pages in use results, one per cycle while out is not stalled
// rst clears control state and the page-in-use flags; no clearing pass
// one item at a time; an output stall holds the block in its result state
module first_fit_record_page_store_core
  import frps_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] key,
  input  logic [15:0]        record_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [1:0]         outcome,
  output logic [4:0]         page_index,
  output logic [5:0]         slot_index,
  output logic [6:0]         count,
  output logic               last
);

  localparam int MEM_DEPTH = MAX_PAGES * MAX_SLOTS;
  localparam int AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int PIW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  state_t state, state_next;

  logic [15:0]           page_size;
  logic [PAGE_IDX_W-1:0] pages_in_use;
  logic [31:0]           cur_key;
  logic [COST_W-1:0]     cur_cost;
  logic [PAGE_IDX_W-1:0] pg;
  logic [REC_CNT_W-1:0]  sl;
  logic                  ins_placed;
  logic [PAGE_IDX_W-1:0] ins_page;
  logic [REC_CNT_W-1:0]  ins_slot;
  logic [31:0]           rdata;
  logic [31:0]           kmem [MEM_DEPTH];

  probe_t                probe [MAX_PAGES+1];
  open_t                 open_cmd;
  logic [REC_CNT_W-1:0]  cnt_arr [MAX_PAGES];
  logic [REC_CNT_W-1:0]  cnt_sel;

  logic                  accept;
  logic                  out_free;
  logic [COST_W-1:0]     in_cost;
  logic [15:0]           init_free;
  logic                  new_fits;
  logic                  pages_full;
  logic                  key_match;
  logic                  mem_we;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;

  logic                  emit;
  logic [1:0]            e_kind;
  logic [1:0]            e_outcome;
  logic [PAGE_IDX_W-1:0] e_page;
  logic [REC_CNT_W-1:0]  e_slot;
  logic [REC_CNT_W-1:0]  e_count;
  logic                  e_last;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign in_cost    = COST_W'(record_size) + RECORD_OVERHEAD;
  assign init_free  = (page_size >= HEADER_BYTES) ? page_size - HEADER_BYTES : 16'd0;
  assign new_fits   = ({1'b0, init_free} >= cur_cost);
  assign pages_full = (pages_in_use >= PAGE_IDX_W'(MAX_PAGES));
  assign cnt_sel    = cnt_arr[pg[PIW-1:0]];
  assign key_match  = (rdata == cur_key);
  assign raddr      = AW'(pg) * AW'(MAX_SLOTS) + AW'(sl);

  // probe enters the first cell on an insert transfer
  always_comb begin
    probe[0]        = '0;
    probe[0].valid  = accept && (cmd_t'(command) == CMD_INSERT);
    probe[0].cost   = in_cost;
  end

  // row of page cells
  for (genvar i = 0; i < MAX_PAGES; i++) begin : g_cell
    frps_cell #(
      .IDX       (i),
      .MAX_SLOTS (MAX_SLOTS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1]),
      .open_cmd  (open_cmd),
      .rec_count (cnt_arr[i])
    );
  end

  // page size register
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= PAGE_SIZE_RESET;
    end else if (cfg_we) begin
      page_size <= cfg_data;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(command))
            CMD_INSERT: state_next = S_INS_SCAN;
            CMD_SEARCH: state_next = S_SRCH_PAGE;
            CMD_REPORT: state_next = S_REP_HEAD;
            CMD_NONE:   state_next = S_IDLE;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (probe[MAX_PAGES].valid) state_next = S_INS_DONE;
      end
      S_INS_DONE, S_SRCH_HIT, S_SRCH_MISS: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SRCH_PAGE: begin
        if (pg == pages_in_use) begin
          state_next = S_SRCH_MISS;
        end else if (sl < cnt_sel) begin
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        state_next = key_match ? S_SRCH_HIT : S_SRCH_PAGE;
      end
      S_REP_HEAD: begin
        if (out_free) state_next = (pages_in_use == '0) ? S_IDLE : S_REP_PAGE;
      end
      S_REP_PAGE: begin
        if (out_free && (pg == pages_in_use - PAGE_IDX_W'(1))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // results, page opens and key writes
  always_comb begin
    emit      = 1'b0;
    e_kind    = KIND_INSERT;
    e_outcome = OUT_EXISTING;
    e_page    = '0;
    e_slot    = '0;
    e_count   = '0;
    e_last    = 1'b1;
    open_cmd  = '0;
    mem_we    = 1'b0;
    waddr     = AW'(ins_page) * AW'(MAX_SLOTS) + AW'(ins_slot);
    unique case (state)
      S_INS_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          priority if (ins_placed) begin
            mem_we = 1'b1;
            e_page = ins_page;
            e_slot = ins_slot;
          end else if (pages_full) begin
            e_outcome = OUT_REFUSED;
          end else begin
            open_cmd.valid = 1'b1;
            open_cmd.page  = pages_in_use;
            open_cmd.free  = new_fits ? init_free - cur_cost[15:0] : init_free;
            open_cmd.fill  = new_fits;
            mem_we         = new_fits;
            waddr          = AW'(pages_in_use) * AW'(MAX_SLOTS);
            e_outcome      = new_fits ? OUT_NEW : OUT_UNFIT;
            e_page         = pages_in_use;
          end
        end
      end
      S_SRCH_HIT: begin
        emit      = out_free;
        e_kind    = KIND_SEARCH;
        e_outcome = OUT_FOUND;
        e_page    = pg;
        e_slot    = sl;
      end
      S_SRCH_MISS: begin
        emit      = out_free;
        e_kind    = KIND_SEARCH;
        e_outcome = OUT_ABSENT;
      end
      S_REP_HEAD: begin
        emit    = out_free;
        e_kind  = KIND_PAGES;
        e_count = REC_CNT_W'(pages_in_use);
        e_last  = (pages_in_use == '0);
      end
      S_REP_PAGE: begin
        emit    = out_free;
        e_kind  = KIND_PAGE;
        e_page  = pg;
        e_count = cnt_sel;
        e_last  = (pg == pages_in_use - PAGE_IDX_W'(1));
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // pages in use count
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= '0;
    end else if (open_cmd.valid) begin
      pages_in_use <= pages_in_use + PAGE_IDX_W'(1);
    end
  end

  // item registers and scan counters
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_key  <= key;
      cur_cost <= in_cost;
      pg       <= '0;
      sl       <= '0;
    end
    if (state == S_INS_SCAN && probe[MAX_PAGES].valid) begin
      ins_placed <= probe[MAX_PAGES].placed;
      ins_page   <= probe[MAX_PAGES].page;
      ins_slot   <= probe[MAX_PAGES].slot;
    end
    if (state == S_SRCH_PAGE && pg != pages_in_use && !(sl < cnt_sel)) begin
      pg <= pg + PAGE_IDX_W'(1);
      sl <= '0;
    end
    if (state == S_SRCH_CMP && !key_match) begin
      sl <= sl + REC_CNT_W'(1);
    end
    if (state == S_REP_PAGE && out_free) begin
      pg <= pg + PAGE_IDX_W'(1);
    end
  end

  // key memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      kmem[waddr] <= cur_key;
    end
    rdata <= kmem[raddr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      result_kind <= e_kind;
      outcome     <= e_outcome;
      page_index  <= 5'(e_page);
      slot_index  <= 6'(e_slot);
      count       <= 7'(e_count);
      last        <= e_last;
    end
  end

  // checks
  a_pages_bounded: assert property (@(posedge clk) disable iff (rst)
    pages_in_use <= PAGE_IDX_W'(MAX_PAGES))
    else $error("page count above capacity");

  a_probe_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_SCAN && probe[MAX_PAGES].valid) |=> (state == S_INS_DONE))
    else $error("insert probe left the row without finishing the insert");

  a_placed_in_use: assert property (@(posedge clk) disable iff (rst)
    (probe[MAX_PAGES].valid && probe[MAX_PAGES].placed) |->
      (probe[MAX_PAGES].page < pages_in_use))
    else $error("record placed in a page not in use");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_INSERT || result_kind == KIND_SEARCH)) |-> last)
    else $error("insert or search answer without last");

endmodule
